### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, masked while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked property that also holds through reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ffha_pkg.sv
package ffha_pkg;

    localparam int ENTRIES      = 16;
    localparam int HEADER_BYTES = 40;
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int CNT_W        = $clog2(ENTRIES + 1);
    localparam int ADDR_W       = 32;
    localparam int SIZE_W       = 24;
    localparam int CFG_IDX_W    = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ADDR_W-1:0] HEAP_START_RST = 32'd65536;
    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 32'hFFFF_FFFF;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_HEAP_START = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_HEAP_LIMIT = t_cfg_idx'(1);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_REUSED    = 3'd0,
        ST_APPENDED  = 3'd1,
        ST_FREED_TOP = 3'd2,
        ST_MARKED    = 3'd3,
        ST_NULL      = 3'd4,
        ST_UNKNOWN   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        K_ALLOC,
        K_FREE,
        K_NULL,
        K_UNKNOWN
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [SIZE_W-1:0]  size;
        logic [ADDR_W-1:0]  addr;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESULT
    } t_state;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_REUSE,
        UPD_POP,
        UPD_MARK,
        UPD_APPEND
    } t_upd;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             busy;
    } t_back_stat;

endpackage

### hdl/ffha_if.sv
interface ffha_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [ffha_pkg::SIZE_W-1:0]   req_size;
    logic [ffha_pkg::ADDR_W-1:0]   block_addr;
    modport source (output valid, req_type, req_size, block_addr, input ready);
    modport sink (input valid, req_type, req_size, block_addr, output ready);
endinterface

interface ffha_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ffha_pkg::ADDR_W-1:0]   user_addr;
    logic [2:0]                    status;
    modport source (output valid, user_addr, status, input ready);
    modport sink (input valid, user_addr, status, output ready);
endinterface

interface ffha_cfg_if;
    logic                          valid;
    logic                          ready;
    ffha_pkg::t_cfg_idx            index;
    logic [ffha_pkg::ADDR_W-1:0]   data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

interface ffha_cmd_if;
    logic                          valid;
    logic                          ready;
    ffha_pkg::t_cmd                cmd;
    modport source (output valid, cmd, input ready);
    modport sink (input valid, cmd, output ready);
endinterface

### hdl/ffha_front.sv
module ffha_front (
    ffha_req_if.sink    i_req,
    ffha_cmd_if.source  o_cmd
);
    import ffha_pkg::*;

    t_cmd cmd;

    // Requests that need no table access are classified here; the back end answers them without a scan.
    always_comb begin
        cmd.size = i_req.req_size;
        cmd.addr = i_req.block_addr;
        if (i_req.req_type == REQ_FREE) begin
            cmd.kind = (i_req.block_addr == '0) ? K_UNKNOWN : K_FREE;
        end else begin
            cmd.kind = (i_req.req_size == '0) ? K_NULL : K_ALLOC;
        end
    end

    assign o_cmd.valid = i_req.valid;
    assign o_cmd.cmd   = cmd;
    assign i_req.ready = o_cmd.ready;

endmodule

### hdl/ffha_queue.sv
module ffha_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffha_cmd_if.sink    i_cmd,
    ffha_cmd_if.source  o_cmd
);
    import ffha_pkg::*;

    t_cmd               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QFILL_W-1:0] r_fill;
    logic               push;
    logic               pop;

    function automatic logic [QPTR_W-1:0] f_next(input logic [QPTR_W-1:0] ptr);
        f_next = (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
    endfunction

    assign i_cmd.ready = (r_fill != QFILL_W'(QUEUE_DEPTH));
    assign o_cmd.valid = (r_fill != '0);
    assign o_cmd.cmd   = r_slot[r_rd_ptr];
    assign push        = i_cmd.valid && i_cmd.ready;
    assign pop         = o_cmd.valid && o_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (push && !pop) begin
                r_fill <= r_fill + QFILL_W'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - QFILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_cmd.cmd;
        end
    end

endmodule

### hdl/ffha_back.sv
module ffha_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ffha_cmd_if.sink             i_cmd,
    ffha_cfg_if.sink             i_cfg,
    ffha_rsp_if.source           o_rsp,
    output ffha_pkg::t_back_stat o_stat
);
    import ffha_pkg::*;

    t_state              r_state;
    t_state              n_state;
    t_cmd                r_cmd;

    logic [ADDR_W-1:0]   r_mem_base [ENTRIES];
    logic [SIZE_W-1:0]   r_mem_size [ENTRIES];
    logic [ENTRIES-1:0]  r_free;
    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_break;
    logic [ADDR_W-1:0]   r_limit;

    logic [CNT_W-1:0]    r_idx;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_idx;
    logic [ADDR_W-1:0]   r_rd_base;
    logic [SIZE_W-1:0]   r_rd_size;
    logic                r_rd_free;

    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_idx;
    logic [ADDR_W-1:0]   r_hit_base;
    logic [SIZE_W-1:0]   r_hit_size;

    logic                r_out_vld;
    logic [ADDR_W-1:0]   r_out_addr;
    t_status             r_out_status;

    logic [ADDR_W:0]     rd_user;
    logic                scan_hit;
    logic                scan_miss;
    logic                issue;
    logic [ADDR_W:0]     hit_user;
    logic [ADDR_W+1:0]   hit_end;
    logic                hit_is_top;
    logic [ADDR_W+1:0]   app_top;
    logic                app_ok;
    logic                out_free;
    logic                take;
    logic                finish;
    t_upd                upd;
    logic [ADDR_W-1:0]   res_addr;
    t_status             res_status;
    logic [IDX_W-1:0]    app_idx;

    assign rd_user   = {1'b0, r_rd_base} + (ADDR_W + 1)'(HEADER_BYTES);
    assign scan_hit  = r_rd_vld && ((r_cmd.kind == K_ALLOC)
                     ? (r_rd_free && (r_rd_size >= r_cmd.size))
                     : (rd_user == {1'b0, r_cmd.addr}));
    assign scan_miss = !r_rd_vld && (r_idx == r_count);
    assign issue     = (r_state == S_SCAN) && !scan_hit && (r_idx != r_count);

    assign hit_user   = {1'b0, r_hit_base} + (ADDR_W + 1)'(HEADER_BYTES);
    assign hit_end    = {2'b0, r_hit_base} + (ADDR_W + 2)'(HEADER_BYTES)
                      + (ADDR_W + 2)'(r_hit_size);
    assign hit_is_top = ((CNT_W'(r_hit_idx) + CNT_W'(1)) == r_count)
                     && (hit_end == {2'b0, r_break});
    assign app_top    = {2'b0, r_break} + (ADDR_W + 2)'(r_cmd.size)
                      + (ADDR_W + 2)'(HEADER_BYTES);
    assign app_ok     = (r_count < CNT_W'(ENTRIES)) && (app_top <= {2'b0, r_limit});
    assign app_idx    = r_count[IDX_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    if (i_cmd.cmd.kind == K_ALLOC || i_cmd.cmd.kind == K_FREE) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RESULT;
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit || scan_miss) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        out_free   = !r_out_vld || o_rsp.ready;
        take       = (r_state == S_IDLE) && i_cmd.valid;
        finish     = (r_state == S_RESULT) && out_free;
        upd        = UPD_NONE;
        res_addr   = '0;
        res_status = ST_NULL;
        unique case (r_cmd.kind)
            K_ALLOC: begin
                if (r_hit) begin
                    upd        = UPD_REUSE;
                    res_addr   = hit_user[ADDR_W-1:0];
                    res_status = ST_REUSED;
                end else if (app_ok) begin
                    upd        = UPD_APPEND;
                    res_addr   = r_break + ADDR_W'(HEADER_BYTES);
                    res_status = ST_APPENDED;
                end
            end
            K_FREE: begin
                if (r_hit) begin
                    upd        = hit_is_top ? UPD_POP : UPD_MARK;
                    res_status = hit_is_top ? ST_FREED_TOP : ST_MARKED;
                end else begin
                    res_status = ST_UNKNOWN;
                end
            end
            K_NULL:    res_status = ST_NULL;
            K_UNKNOWN: res_status = ST_UNKNOWN;
            default:   res_status = ST_NULL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_free    <= '0;
            r_break   <= HEAP_START_RST;
            r_limit   <= HEAP_LIMIT_RST;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_hit     <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state <= n_state;
            if (take) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
                r_hit    <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_idx <= r_idx + CNT_W'(1);
                end
                if (scan_hit) begin
                    r_hit <= 1'b1;
                end
            end
            if (finish) begin
                unique case (upd)
                    UPD_REUSE: r_free[r_hit_idx] <= 1'b0;
                    UPD_MARK:  r_free[r_hit_idx] <= 1'b1;
                    UPD_POP: begin
                        r_free[r_hit_idx] <= 1'b0;
                        r_count           <= CNT_W'(r_hit_idx);
                        r_break           <= r_hit_base;
                    end
                    UPD_APPEND: begin
                        r_free[app_idx] <= 1'b0;
                        r_count         <= r_count + CNT_W'(1);
                        r_break         <= app_top[ADDR_W-1:0];
                    end
                    default: ;
                endcase
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_HEAP_START: begin
                        if (r_count == '0) begin
                            r_break <= i_cfg.data;
                        end
                    end
                    CFG_HEAP_LIMIT: r_limit <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= i_cmd.cmd;
        end
        if (issue) begin
            r_rd_idx  <= r_idx[IDX_W-1:0];
            r_rd_base <= r_mem_base[r_idx[IDX_W-1:0]];
            r_rd_size <= r_mem_size[r_idx[IDX_W-1:0]];
            r_rd_free <= r_free[r_idx[IDX_W-1:0]];
        end
        if (r_state == S_SCAN && scan_hit) begin
            r_hit_idx  <= r_rd_idx;
            r_hit_base <= r_rd_base;
            r_hit_size <= r_rd_size;
        end
        if (finish && upd == UPD_APPEND) begin
            r_mem_base[app_idx] <= r_break;
            r_mem_size[app_idx] <= r_cmd.size;
        end
        if (finish) begin
            r_out_addr   <= res_addr;
            r_out_status <= res_status;
        end
    end

    assign i_cmd.ready     = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.user_addr = r_out_addr;
    assign o_rsp.status    = r_out_status;
    assign o_stat.count    = r_count;
    assign o_stat.busy     = (r_state != S_IDLE);

endmodule

### hdl/first_fit_heap_allocator_unit.sv
// The back end works on one item at a time, scanning one table entry per cycle; a queue ahead
// of it holds further items. Zero-size allocates and null frees need no scan. A stalled
// result holds the back end. Synchronous active-low reset empties the table, sets the break
// to 65536 and the limit to the top of the address space, and drops pending items.
`include "assert_macros.svh"

module first_fit_heap_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ffha_req_if.sink    i_req,
    ffha_cfg_if.sink    i_cfg,
    ffha_rsp_if.source  o_rsp
);
    import ffha_pkg::*;

    ffha_cmd_if  w_front_cmd ();
    ffha_cmd_if  w_back_cmd ();
    t_back_stat  back_stat;

    ffha_front u_front (
        .i_req (i_req),
        .o_cmd (w_front_cmd)
    );

    ffha_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_front_cmd),
        .o_cmd   (w_back_cmd)
    );

    ffha_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_back_cmd),
        .i_cfg   (i_cfg),
        .o_rsp   (o_rsp),
        .o_stat  (back_stat)
    );

    `ASSERT_ALWAYS(a_no_rsp_after_reset, i_clk, !i_rst_n |=> !o_rsp.valid, "result after reset")
    `ASSERT_CLK(a_free_addr_zero, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status == ST_FREED_TOP || o_rsp.status == ST_MARKED || o_rsp.status == ST_UNKNOWN || o_rsp.status == ST_NULL) |-> o_rsp.user_addr == '0, "nonzero address on free or null")
    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, back_stat.count <= CNT_W'(ENTRIES), "entry count past table size")
    `ASSERT_CLK(a_rsp_from_busy, i_clk, i_rst_n, $rose(o_rsp.valid) |-> $past(back_stat.busy), "result without work")

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import ffha_pkg::*;

    localparam int TOP_W       = ADDR_W + 2;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [ADDR_W-1:0] user_addr;
        t_status           status;
    } alloc_result_t;

    // Tracks the block table and heap break, and holds the results still owed by the block.
    class heap_tracker;
        logic [ADDR_W-1:0] blk_base [ENTRIES];
        logic [SIZE_W-1:0] blk_size [ENTRIES];
        logic              blk_free [ENTRIES];
        int                blk_count;
        logic [ADDR_W-1:0] brk;
        logic [ADDR_W-1:0] start_reg;
        logic [ADDR_W-1:0] limit_reg;
        alloc_result_t     owed_results[$];
        int                errors;
        int                checked;
        int                n_reqs;
        int                tally[6];

        function new();
            start_reg = HEAP_START_RST;
            limit_reg = HEAP_LIMIT_RST;
            brk       = HEAP_START_RST;
            blk_count = 0;
            errors    = 0;
            checked   = 0;
            n_reqs    = 0;
            foreach (blk_free[i]) begin
                blk_base[i] = '0;
                blk_size[i] = '0;
                blk_free[i] = 1'b0;
            end
            foreach (tally[i]) tally[i] = 0;
        endfunction

        function logic [ADDR_W-1:0] user_of(int i);
            return blk_base[i] + ADDR_W'(HEADER_BYTES);
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        function void write_reg(t_cfg_idx idx, logic [ADDR_W-1:0] val);
            if (idx == CFG_HEAP_START) begin
                start_reg = val;
                if (blk_count == 0) brk = val;
            end else if (idx == CFG_HEAP_LIMIT) begin
                limit_reg = val;
            end
        endfunction

        function void push_owed(logic [ADDR_W-1:0] ua, t_status st);
            alloc_result_t r;
            r.user_addr = ua;
            r.status    = st;
            owed_results.push_back(r);
        endfunction

        function void predict_alloc(logic [SIZE_W-1:0] sz);
            logic [TOP_W-1:0] top;
            int               i;
            if (sz == '0) begin
                push_owed('0, ST_NULL);
                return;
            end
            for (i = 0; i < blk_count; i++) begin
                if (blk_free[i] && blk_size[i] >= sz) begin
                    blk_free[i] = 1'b0;
                    push_owed(user_of(i), ST_REUSED);
                    return;
                end
            end
            top = TOP_W'(brk) + TOP_W'(sz) + TOP_W'(HEADER_BYTES);
            if (blk_count >= ENTRIES || top > TOP_W'(limit_reg)) begin
                push_owed('0, ST_NULL);
                return;
            end
            blk_base[blk_count] = brk;
            blk_size[blk_count] = sz;
            blk_free[blk_count] = 1'b0;
            push_owed(user_of(blk_count), ST_APPENDED);
            blk_count++;
            brk = top[ADDR_W-1:0];
        endfunction

        function void predict_free(logic [ADDR_W-1:0] addr);
            logic [TOP_W-1:0] blk_end;
            int               hit;
            int               i;
            hit = -1;
            if (addr == '0) begin
                push_owed('0, ST_UNKNOWN);
                return;
            end
            for (i = 0; i < blk_count && hit < 0; i++) begin
                if (TOP_W'(blk_base[i]) + TOP_W'(HEADER_BYTES) == TOP_W'(addr)) hit = i;
            end
            if (hit < 0) begin
                push_owed('0, ST_UNKNOWN);
                return;
            end
            blk_end = TOP_W'(blk_base[hit]) + TOP_W'(HEADER_BYTES) + TOP_W'(blk_size[hit]);
            if (hit == blk_count - 1 && blk_end == TOP_W'(brk)) begin
                brk           = blk_base[hit];
                blk_free[hit] = 1'b0;
                blk_count     = hit;
                push_owed('0, ST_FREED_TOP);
            end else begin
                blk_free[hit] = 1'b1;
                push_owed('0, ST_MARKED);
            end
        endfunction

        function void note_request(logic typ, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] addr);
            n_reqs++;
            if (typ == REQ_ALLOC) predict_alloc(sz);
            else predict_free(addr);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 100) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_result(logic [ADDR_W-1:0] ua, logic [2:0] st);
            alloc_result_t want;
            if (owed_results.size() == 0) begin
                report($sformatf("result with nothing owed: user_addr=%h status=%0d", ua, st));
                return;
            end
            want = owed_results.pop_front();
            checked++;
            tally[want.status]++;
            if (st != want.status) begin
                report($sformatf("status %0d, expected %0d", st, want.status));
            end
            if (ua != want.user_addr) begin
                report($sformatf("user_addr %h, expected %h", ua, want.user_addr));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    bit          hold_request = 1'b0;
    int          n_writes = 0;
    heap_tracker tracker = new();

    ffha_req_if u_req ();
    ffha_cfg_if u_cfg ();
    ffha_rsp_if u_rsp ();

    first_fit_heap_allocator_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (u_req),
        .i_cfg   (u_cfg),
        .o_rsp   (u_rsp)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && u_rsp.valid && u_rsp.ready) begin
            tracker.check_result(u_rsp.user_addr, u_rsp.status);
        end
    end

    // Result sink: changes its stall pattern now and then, and holds off completely on request.
    initial begin : rsp_sink
        int mode;
        int mode_left;
        int hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        u_rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                u_rsp.ready <= 1'b0;
            end else begin
                case (mode)
                    0: begin
                        u_rsp.ready <= 1'b1;
                    end
                    1: begin
                        u_rsp.ready <= 1'($urandom_range(0, 1));
                    end
                    2: begin
                        u_rsp.ready <= ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        u_rsp.ready <= ((mode_left / 8) % 2 == 0);
                    end
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((u_req.valid && u_req.ready) || (u_rsp.valid && u_rsp.ready)
                    || (u_cfg.valid && u_cfg.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Watchdog: no item moved for %0d cycles.", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_req(logic typ, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] addr);
        u_req.valid      <= 1'b1;
        u_req.req_type   <= typ;
        u_req.req_size   <= sz;
        u_req.block_addr <= addr;
        do @(posedge i_clk); while (!u_req.ready);
        tracker.note_request(typ, sz, addr);
    endtask

    task automatic idle_req(int cycles);
        if (cycles > 0) begin
            u_req.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_results();
        u_req.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [ADDR_W-1:0] val);
        wait_results();
        repeat (8) @(posedge i_clk);
        u_cfg.valid <= 1'b1;
        u_cfg.index <= idx;
        u_cfg.data  <= val;
        do @(posedge i_clk); while (!u_cfg.ready);
        tracker.write_reg(idx, val);
        n_writes++;
        u_cfg.valid <= 1'b0;
    endtask

    task automatic send_random(int alloc_pct, int size_cap);
        logic [SIZE_W-1:0] sz;
        logic [ADDR_W-1:0] ad;
        int                sel;
        int                i;
        sz  = SIZE_W'($urandom);
        ad  = ADDR_W'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < alloc_pct) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                sz = '0;
            end else if (sel < 30 && tracker.blk_count > 0) begin
                // Sizes right at the fit boundary of an existing entry.
                i  = $urandom_range(0, tracker.blk_count - 1);
                sz = tracker.blk_size[i] + SIZE_W'($urandom_range(0, 2)) - SIZE_W'(1);
            end else if (sel >= 40) begin
                sz = SIZE_W'($urandom_range(1, size_cap));
            end
            send_req(REQ_ALLOC, sz, ad);
        end else begin
            sel = $urandom_range(0, 99);
            if (tracker.blk_count > 0 && sel < 60) begin
                ad = tracker.user_of($urandom_range(0, tracker.blk_count - 1));
            end else if (tracker.blk_count > 0 && sel < 75) begin
                ad = tracker.user_of(tracker.blk_count - 1);
            end else if (tracker.blk_count > 0 && sel < 85) begin
                ad = tracker.user_of($urandom_range(0, tracker.blk_count - 1))
                     + ADDR_W'($urandom_range(1, 7));
            end else if (sel < 92) begin
                ad = '0;
            end
            send_req(REQ_FREE, sz, ad);
        end
    endtask

    task automatic run_random(int n, int alloc_pct, int size_cap);
        int burst;
        burst = $urandom_range(1, 40);
        repeat (n) begin
            send_random(alloc_pct, size_cap);
            burst--;
            if (burst == 0) begin
                idle_req(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25));
                burst = $urandom_range(1, 40);
            end
        end
    endtask

    task automatic flood_during_hold(int n, int size_cap);
        hold_request = 1'b1;
        repeat (n) send_random(55, size_cap);
    endtask

    task automatic drain_heap();
        while (tracker.blk_count > 0) begin
            send_req(REQ_FREE, SIZE_W'($urandom), tracker.user_of(tracker.blk_count - 1));
        end
    endtask

    task automatic run_directed();
        send_req(REQ_ALLOC, '0, '1);
        send_req(REQ_FREE, '1, '0);
        send_req(REQ_FREE, '0, '1);
        send_req(REQ_ALLOC, SIZE_W'(1), '0);
        send_req(REQ_ALLOC, '1, '0);
        send_req(REQ_ALLOC, SIZE_W'(100), '1);
        send_req(REQ_FREE, '0, tracker.user_of(0));
        send_req(REQ_ALLOC, SIZE_W'(2), '0);
        send_req(REQ_FREE, '0, tracker.user_of(1));
        send_req(REQ_FREE, '0, tracker.user_of(1));
        send_req(REQ_ALLOC, '1, '0);
        send_req(REQ_FREE, '0, tracker.user_of(1) + 1);
        send_req(REQ_FREE, '0, tracker.user_of(1) - 1);
        send_req(REQ_ALLOC, SIZE_W'(1), '0);
        drain_heap();
        send_req(REQ_FREE, '0, HEAP_START_RST + ADDR_W'(HEADER_BYTES));
    endtask

    initial begin : stimulus
        i_rst_n          <= 1'b0;
        u_req.valid      <= 1'b0;
        u_req.req_type   <= REQ_ALLOC;
        u_req.req_size   <= '0;
        u_req.block_addr <= '0;
        u_cfg.valid      <= 1'b0;
        u_cfg.index      <= CFG_HEAP_START;
        u_cfg.data       <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        run_random(250, 55, 2000);
        flood_during_hold(12, 2000);
        wait_results();
        run_random(250, 60, 2000);
        drain_heap();

        cfg_write(CFG_HEAP_START, '0);
        cfg_write(CFG_HEAP_LIMIT, ADDR_W'(4000));
        run_random(300, 60, 400);
        drain_heap();

        cfg_write(CFG_HEAP_START, '1);
        run_random(20, 55, 400);
        cfg_write(CFG_HEAP_START, 32'hFFFF_FF00);
        cfg_write(CFG_HEAP_LIMIT, '1);
        run_random(150, 55, 60);
        drain_heap();

        cfg_write(CFG_HEAP_START, 32'h1000_0000);
        run_random(300, 55, 5000);

        cfg_write(CFG_HEAP_START, 32'h0000_2000);
        cfg_write(CFG_HEAP_LIMIT, '0);
        run_random(200, 50, 5000);

        cfg_write(CFG_HEAP_LIMIT, '1);
        run_random(150, 55, 3000);
        flood_during_hold(12, 3000);
        run_random(150, 55, 3000);

        wait_results();
        repeat (30) @(posedge i_clk);
        $display("Run covered %0d requests over %0d register writes: %0d appended, %0d reused,",
                 tracker.n_reqs, n_writes, tracker.tally[ST_APPENDED], tracker.tally[ST_REUSED]);
        $display("%0d popped, %0d marked free, %0d null, %0d unknown frees; %0d mismatches.",
                 tracker.tally[ST_FREED_TOP], tracker.tally[ST_MARKED], tracker.tally[ST_NULL],
                 tracker.tally[ST_UNKNOWN], tracker.errors);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
